/* hw/rtl/sbca_pkg.sv */
// shared types and constants of the segmented bitmap cell allocator
package sbca_pkg;

  localparam int MAX_SEGMENTS      = 8;
  localparam int CELLS_PER_SEGMENT = 64;
  localparam int CELL_LIMIT        = (CELLS_PER_SEGMENT < 64) ? CELLS_PER_SEGMENT : 64;
  localparam int BIT_W             = $clog2(CELL_LIMIT);
  localparam int CELL_W            = 9;
  localparam int IDXSEG_W          = CELL_W - BIT_W;
  localparam int CPS_W             = 7;
  localparam int SEGOUT_W          = 4;
  localparam int CFG_IDX_W         = 2;

  localparam logic [CPS_W-1:0] CPS_RESET = CPS_W'(64);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_NEXT  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_FREE      = 3'd1,
    ST_NO_NEXT      = 3'd2,
    ST_BAD_INDEX    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS      = 2'd0,
    CFG_EXPANDABLE = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic idle;
    logic latch;
    logic decode;
    logic scan;
    logic free_chk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic imm;
    logic is_free;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/segmented_bitmap_cell_allocator_core.sv */
// top level of the segmented bitmap cell allocator
//
// usage: one request word enters on the in_ channel (valid/stall) and yields
// exactly one result word on the out_ channel (valid/stall). requests are
// allocate (first free cell, first segment first), free, next used cell and
// clear all. results carry a status, a cell index and the active segment count.
// config words (cells per segment, expansion enable) enter on cfg_ while idle;
// a cells-per-segment write starts a fresh pool with one active segment.
// sequence: an accepted request is decoded, then scanned (allocate and next,
// one segment bitmap read and priority-encoded per cycle, up to MAX_SEGMENTS
// segments) or checked (free) before its result word is loaded; clear and
// rejected requests skip the scan. one request is worked on at a time; in_stall
// is high while busy, so a new request is taken only once the last has finished.
// the output register holds a finished word while out_stall is high; a later
// request finishes and then waits, with in_stall high, until the register frees.
// reset: all cells free, segment 0 active, 64 cells per segment, expansion on.
module segmented_bitmap_cell_allocator_core #(
  parameter int MAX_SEGMENTS = sbca_pkg::MAX_SEGMENTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [sbca_pkg::CELL_W-1:0]     in_cell_index,
  input  logic                            in_from_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [sbca_pkg::CELL_W-1:0]     out_result_cell,
  output logic [sbca_pkg::SEGOUT_W-1:0]   out_segments_in_use,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbca_pkg::CPS_W-1:0]      cfg_data
);

  sbca_pkg::cmd_t cmd;
  sbca_pkg::sts_t sts;

  sbca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbca_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_cell_index       (in_cell_index),
    .in_from_start       (in_from_start),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_cell     (out_result_cell),
    .out_segments_in_use (out_segments_in_use)
  );

  assign cfg_ready = cmd.idle;

endmodule

/* hw/rtl/sbca_ctrl.sv */
// request sequencer of the cell allocator
module sbca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbca_pkg::sts_t sts,
  output sbca_pkg::cmd_t cmd
);

  sbca_pkg::state_t state_r;
  sbca_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      sbca_pkg::S_IDLE: begin
        cmd.idle  = rst_n;
        cmd.latch = in_valid && rst_n;
        if (in_valid && rst_n) begin
          state_nxt = sbca_pkg::S_DECODE;
        end
      end
      sbca_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.imm) begin
          state_nxt = sbca_pkg::S_EMIT;
        end else if (sts.is_free) begin
          state_nxt = sbca_pkg::S_FREE;
        end else begin
          state_nxt = sbca_pkg::S_SCAN;
        end
      end
      sbca_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sbca_pkg::S_EMIT;
        end
      end
      sbca_pkg::S_FREE: begin
        cmd.free_chk = 1'b1;
        state_nxt    = sbca_pkg::S_EMIT;
      end
      sbca_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = sbca_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sbca_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = !cmd.idle;

endmodule

/* hw/rtl/sbca_dpath.sv */
// bitmap store, segment scan, config registers and output register
module sbca_dpath #(
  parameter int MAX_SEGMENTS = sbca_pkg::MAX_SEGMENTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sbca_pkg::cmd_t                  cmd,
  output sbca_pkg::sts_t                  sts,
  input  logic [1:0]                      in_req_type,
  input  logic [sbca_pkg::CELL_W-1:0]     in_cell_index,
  input  logic                            in_from_start,
  input  logic                            cfg_valid,
  input  logic [sbca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbca_pkg::CPS_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [sbca_pkg::CELL_W-1:0]     out_result_cell,
  output logic [sbca_pkg::SEGOUT_W-1:0]   out_segments_in_use
);

  localparam int NB     = sbca_pkg::CELL_LIMIT;
  localparam int BW     = sbca_pkg::BIT_W;
  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int CW     = (CNT_W > sbca_pkg::IDXSEG_W + 1) ? CNT_W : sbca_pkg::IDXSEG_W + 1;

  function automatic logic [BW-1:0] lowest_set(input logic [NB-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [sbca_pkg::CELL_W-1:0] cell_id(input logic [CW-1:0] s,
                                                          input logic [BW-1:0] b);
    return sbca_pkg::CELL_W'(32'(s) * sbca_pkg::CELLS_PER_SEGMENT + 32'(b));
  endfunction

  logic [NB-1:0] used_mem [MAX_SEGMENTS];

  logic [sbca_pkg::CPS_W-1:0]  cps_r;
  logic                        exp_r;
  logic [CNT_W-1:0]            active_r;
  logic [MAX_SEGMENTS-1:0]     seg_valid_r;
  logic                        out_valid_r;

  sbca_pkg::req_t              req_r;
  logic [sbca_pkg::CELL_W-1:0] idx_r;
  logic                        fs_r;
  logic [CW-1:0]               cur_seg_r;
  logic [BW-1:0]               start_bit_r;
  logic                        first_r;
  logic [NB-1:0]               rd_data_r;
  logic                        rd_vld_r;
  sbca_pkg::status_t           res_status_r;
  logic [sbca_pkg::CELL_W-1:0] res_cell_r;
  logic [2:0]                  out_status_r;
  logic [sbca_pkg::CELL_W-1:0] out_cell_r;
  logic [sbca_pkg::SEGOUT_W-1:0] out_segs_r;

  logic [sbca_pkg::CPS_W-1:0]  n_eff;
  logic [NB-1:0]               nmask;
  logic [NB-1:0]               smask;
  logic [CW-1:0]               sg;
  logic [BW-1:0]               cl;
  logic                        bad;
  logic [BW:0]                 nb;
  logic                        wrap;
  logic [CW-1:0]               nx_seg;
  logic [BW-1:0]               nx_bit;
  logic [CW-1:0]               start_seg;
  logic                        dec_imm;
  sbca_pkg::status_t           dec_status;
  logic [NB-1:0]               word;
  logic [NB-1:0]               cand;
  logic                        hit;
  logic [BW-1:0]               hb;
  logic [CW-1:0]               seg_inc;
  logic                        last;
  logic                        can_grow;
  logic                        grow;
  logic [SEG_AW-1:0]           rd_addr;
  logic                        wr_en;
  logic [SEG_AW-1:0]           wr_addr;
  logic [NB-1:0]               wr_data;
  logic                        cfg_cells_wr;

  always_comb begin
    if (cps_r == '0) begin
      n_eff = sbca_pkg::CPS_W'(1);
    end else if (cps_r > sbca_pkg::CPS_W'(NB)) begin
      n_eff = sbca_pkg::CPS_W'(NB);
    end else begin
      n_eff = cps_r;
    end
    for (int i = 0; i < NB; i++) begin
      nmask[i] = (sbca_pkg::CPS_W'(i) < n_eff);
      smask[i] = !first_r || (BW'(i) >= start_bit_r);
    end

    sg   = CW'(idx_r / sbca_pkg::CELLS_PER_SEGMENT);
    cl   = BW'(idx_r % sbca_pkg::CELLS_PER_SEGMENT);
    bad  = (sg >= CW'(active_r)) || (sbca_pkg::CPS_W'(cl) >= n_eff);
    nb   = (BW + 1)'(cl) + (BW + 1)'(1);
    wrap = (sbca_pkg::CPS_W'(nb) >= n_eff);
    if (fs_r) begin
      nx_seg = '0;
      nx_bit = '0;
    end else if (wrap) begin
      nx_seg = CW'(sg + CW'(1));
      nx_bit = '0;
    end else begin
      nx_seg = sg;
      nx_bit = nb[BW-1:0];
    end

    case (req_r)
      sbca_pkg::REQ_FREE: start_seg = sg;
      sbca_pkg::REQ_NEXT: start_seg = nx_seg;
      default:            start_seg = '0;
    endcase

    dec_imm    = 1'b0;
    dec_status = sbca_pkg::ST_OK;
    case (req_r)
      sbca_pkg::REQ_CLEAR: begin
        dec_imm = 1'b1;
      end
      sbca_pkg::REQ_FREE: begin
        dec_imm    = bad;
        dec_status = sbca_pkg::ST_BAD_INDEX;
      end
      sbca_pkg::REQ_NEXT: begin
        if (!fs_r && bad) begin
          dec_imm    = 1'b1;
          dec_status = sbca_pkg::ST_BAD_INDEX;
        end else if (nx_seg >= CW'(active_r)) begin
          dec_imm    = 1'b1;
          dec_status = sbca_pkg::ST_NO_NEXT;
        end
      end
      default: begin
        dec_imm = 1'b0;
      end
    endcase

    word = rd_vld_r ? rd_data_r : '0;
    if (req_r == sbca_pkg::REQ_ALLOC) begin
      cand = ~word & nmask;
    end else begin
      cand = word & nmask & smask;
    end
    hit      = |cand;
    hb       = lowest_set(cand);
    seg_inc  = CW'(cur_seg_r + CW'(1));
    last     = (seg_inc >= CW'(active_r));
    can_grow = exp_r && (active_r < CNT_W'(MAX_SEGMENTS));
    grow     = cmd.scan && (req_r == sbca_pkg::REQ_ALLOC) && !hit && last && can_grow;

    rd_addr = cmd.scan ? SEG_AW'(seg_inc) : SEG_AW'(start_seg);

    wr_en   = 1'b0;
    wr_addr = SEG_AW'(cur_seg_r);
    wr_data = word | (NB'(1) << hb);
    if (cmd.scan && (req_r == sbca_pkg::REQ_ALLOC)) begin
      if (hit) begin
        wr_en = 1'b1;
      end else if (grow) begin
        wr_en   = 1'b1;
        wr_addr = SEG_AW'(active_r);
        wr_data = NB'(1);
      end
    end else if (cmd.free_chk && word[cl]) begin
      wr_en   = 1'b1;
      wr_data = word & ~(NB'(1) << cl);
    end

    cfg_cells_wr = cfg_valid && cmd.idle && (cfg_index == sbca_pkg::CFG_CELLS);

    sts.imm       = dec_imm;
    sts.is_free   = (req_r == sbca_pkg::REQ_FREE);
    sts.scan_done = hit || last;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // bitmap store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= used_mem[rd_addr];
    rd_vld_r  <= seg_valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r       <= sbca_pkg::CPS_RESET;
      exp_r       <= 1'b1;
      active_r    <= CNT_W'(1);
      seg_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_cells_wr) begin
        cps_r       <= cfg_data;
        active_r    <= CNT_W'(1);
        seg_valid_r <= '0;
      end else begin
        if (cmd.decode && (req_r == sbca_pkg::REQ_CLEAR)) begin
          seg_valid_r <= '0;
        end
        if (wr_en) begin
          seg_valid_r[wr_addr] <= 1'b1;
        end
        if (grow) begin
          active_r <= CNT_W'(active_r + CNT_W'(1));
        end
      end
      if (cfg_valid && cmd.idle && (cfg_index == sbca_pkg::CFG_EXPANDABLE)) begin
        exp_r <= cfg_data[0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= sbca_pkg::req_t'(in_req_type);
      idx_r <= in_cell_index;
      fs_r  <= in_from_start;
    end
    if (cmd.decode) begin
      cur_seg_r    <= start_seg;
      start_bit_r  <= (req_r == sbca_pkg::REQ_NEXT) ? nx_bit : '0;
      first_r      <= 1'b1;
      res_status_r <= dec_status;
      res_cell_r   <= '0;
    end
    if (cmd.scan) begin
      first_r <= 1'b0;
      if (hit) begin
        res_status_r <= sbca_pkg::ST_OK;
        res_cell_r   <= cell_id(cur_seg_r, hb);
      end else if (last) begin
        if (grow) begin
          res_status_r <= sbca_pkg::ST_OK;
          res_cell_r   <= cell_id(CW'(active_r), '0);
        end else begin
          res_cell_r <= '0;
          if (req_r == sbca_pkg::REQ_ALLOC) begin
            res_status_r <= sbca_pkg::ST_NO_FREE;
          end else begin
            res_status_r <= sbca_pkg::ST_NO_NEXT;
          end
        end
      end else begin
        cur_seg_r <= seg_inc;
      end
    end
    if (cmd.free_chk) begin
      res_cell_r   <= '0;
      res_status_r <= word[cl] ? sbca_pkg::ST_OK : sbca_pkg::ST_ALREADY_FREE;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_cell_r   <= res_cell_r;
      out_segs_r   <= sbca_pkg::SEGOUT_W'(active_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_cell     = out_cell_r;
  assign out_segments_in_use = out_segs_r;

endmodule

/* tb/tb_segmented_bitmap_cell_allocator_core.sv */
// self-checking testbench for the segmented bitmap cell allocator core
module tb_segmented_bitmap_cell_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sbca_pkg::*;

  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 213;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

  typedef struct packed {
    req_t                kind;
    logic [CELL_W-1:0]   idx;
    logic                fs;
  } req_word_t;

  typedef struct {
    status_t               status;
    logic [CELL_W-1:0]     slot;
    logic [SEGOUT_W-1:0]   segs;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_req_type = '0;
  logic [CELL_W-1:0]     in_cell_index = '0;
  logic                  in_from_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic [CELL_W-1:0]     out_result_cell;
  logic [SEGOUT_W-1:0]   out_segments_in_use;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CPS_W-1:0]      cfg_data = '0;

  segmented_bitmap_cell_allocator_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_cell_index       (in_cell_index),
    .in_from_start       (in_from_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_cell     (out_result_cell),
    .out_segments_in_use (out_segments_in_use),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // pool model
  logic [63:0]       seg_map [MAX_SEGMENTS];
  int unsigned       seg_free [MAX_SEGMENTS];
  int unsigned       segs_live;
  logic [CPS_W-1:0]  cells_reg;
  logic              grow_reg;

  req_word_t      req_queue [$];
  alloc_result_t  due_results [$];
  req_word_t      cur_word;
  alloc_result_t  want;

  int snd_pct = 7;
  int rcv_pct = 55;
  int n_accepted = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_errors = 0;
  int n_cycles = 0;
  int hold_left = 0;
  int hold_mark = -1;
  int status_hits [5] = '{default: 0};

  function automatic int unsigned usable_cells();
    int unsigned n;
    n = cells_reg;
    if (n < 1) n = 1;
    if (n > CELL_LIMIT) n = CELL_LIMIT;
    return n;
  endfunction

  function automatic void reload_pool();
    for (int s = 0; s < MAX_SEGMENTS; s++) begin
      seg_map[s] = '0;
      seg_free[s] = usable_cells();
    end
    segs_live = 1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CPS_W-1:0] val);
    if (idx == CFG_CELLS) begin
      cells_reg = val;
      reload_pool();
    end else if (idx == CFG_EXPANDABLE) begin
      grow_reg = val[0];
    end
  endfunction

  function automatic alloc_result_t serve_request(req_word_t rq);
    alloc_result_t r;
    int unsigned n, seg, bitpos, s, b;
    logic hit;
    n = usable_cells();
    r.status = ST_OK;
    r.slot = '0;
    hit = 1'b0;
    case (rq.kind)
      REQ_ALLOC: begin
        for (s = 0; s < segs_live && !hit; s++) begin
          if (seg_free[s] != 0) begin
            for (b = 0; b < n && !hit; b++) begin
              if (!seg_map[s][b]) begin
                seg_map[s][b] = 1'b1;
                seg_free[s]--;
                r.slot = CELL_W'(s * CELLS_PER_SEGMENT + b);
                hit = 1'b1;
              end
            end
          end
        end
        if (!hit) begin
          if (grow_reg && segs_live < MAX_SEGMENTS) begin
            seg_map[segs_live] = 64'd1;
            seg_free[segs_live] = n - 1;
            r.slot = CELL_W'(segs_live * CELLS_PER_SEGMENT);
            segs_live++;
          end else begin
            r.status = ST_NO_FREE;
          end
        end
      end
      REQ_CLEAR: begin
        for (s = 0; s < MAX_SEGMENTS; s++) begin
          seg_map[s] = '0;
          seg_free[s] = n;
        end
      end
      default: begin
        seg = 0;
        bitpos = 0;
        if (rq.kind == REQ_FREE || !rq.fs) begin
          seg = rq.idx / CELLS_PER_SEGMENT;
          bitpos = rq.idx % CELLS_PER_SEGMENT;
          if (seg >= segs_live || bitpos >= n) r.status = ST_BAD_INDEX;
        end
        if (r.status == ST_OK) begin
          if (rq.kind == REQ_FREE) begin
            if (!seg_map[seg][bitpos]) begin
              r.status = ST_ALREADY_FREE;
            end else begin
              seg_map[seg][bitpos] = 1'b0;
              seg_free[seg]++;
            end
          end else begin
            if (!rq.fs) begin
              bitpos++;
              if (bitpos >= n) begin
                bitpos = 0;
                seg++;
              end
            end
            r.status = ST_NO_NEXT;
            for (s = seg; s < segs_live && r.status != ST_OK; s++) begin
              for (b = (s == seg) ? bitpos : 0; b < n && r.status != ST_OK; b++) begin
                if (seg_map[s][b]) begin
                  r.status = ST_OK;
                  r.slot = CELL_W'(s * CELLS_PER_SEGMENT + b);
                end
              end
            end
          end
        end
      end
    endcase
    if (r.status != ST_OK) r.slot = '0;
    r.segs = SEGOUT_W'(segs_live);
    return r;
  endfunction

  function automatic void push_req(req_t kind, logic [CELL_W-1:0] idx, logic fs);
    req_word_t w;
    w.kind = kind;
    w.idx = idx;
    w.fs = fs;
    req_queue.push_back(w);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CPS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    n_writes++;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk); while (req_queue.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input logic reload, input logic [CPS_W-1:0] cps,
                           input logic [CPS_W-1:0] grow, input int spct, input int rpct);
    int unsigned n, r;
    req_t kind;
    logic [CELL_W-1:0] idx;
    if (reload) write_reg(CFG_CELLS, cps);
    write_reg(CFG_EXPANDABLE, grow);
    snd_pct = spct;
    rcv_pct = rpct;
    n = usable_cells();
    repeat (PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 45) kind = REQ_ALLOC;
      else if (r < 75) kind = REQ_FREE;
      else if (r < 97) kind = REQ_NEXT;
      else kind = REQ_CLEAR;
      if ($urandom_range(4) == 0) begin
        idx = CELL_W'($urandom_range(511));
      end else begin
        idx = CELL_W'($urandom_range(MAX_SEGMENTS - 1) * CELLS_PER_SEGMENT +
                      $urandom_range(n - 1));
      end
      push_req(kind, idx, 1'($urandom_range(1)));
    end
    drain();
  endtask

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(serve_request(cur_word));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= snd_pct) begin
          cur_word = req_queue.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_word.kind;
          in_cell_index <= cur_word.idx;
          in_from_start <= cur_word.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the core backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((n_accepted == 150 || n_accepted == 1000) && hold_mark != n_accepted) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= n_accepted;
    end
  end

  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_pct);
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: status %0d, result_cell %0d, segments_in_use %0d",
               out_status, out_result_cell, out_segments_in_use);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
        if (out_result_cell !== want.slot) begin
          $error("result_cell: expected %0d, got %0d", want.slot, out_result_cell);
          n_errors++;
        end
        if (out_segments_in_use !== want.segs) begin
          $error("segments_in_use: expected %0d, got %0d", want.segs, out_segments_in_use);
          n_errors++;
        end
        status_hits[int'(want.status)]++;
        n_checked++;
      end
    end
  end

  initial begin
    while (n_cycles < LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("tb_segmented_bitmap_cell_allocator_core: done, errors");
    $finish;
  end

  initial begin
    cells_reg = CPS_RESET;
    grow_reg = 1'b1;
    reload_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, 64 cells, expansion on
    push_req(REQ_NEXT, '0, 1'b1);
    push_req(REQ_FREE, '0, 1'b0);
    push_req(REQ_ALLOC, '0, 1'b0);
    push_req(REQ_ALLOC, '1, 1'b1);
    push_req(REQ_NEXT, '0, 1'b0);
    push_req(REQ_FREE, CELL_W'(CELLS_PER_SEGMENT), 1'b0);
    push_req(REQ_NEXT, '1, 1'b0);
    push_req(REQ_FREE, '0, 1'b1);
    push_req(REQ_FREE, '0, 1'b0);
    push_req(REQ_CLEAR, '1, 1'b1);
    drain();

    // zero cell count acts as one, grow through every segment
    write_reg(CFG_CELLS, '0);
    write_reg(CFG_EXPANDABLE, CPS_W'(1));
    repeat (MAX_SEGMENTS + 1) push_req(REQ_ALLOC, '0, 1'b0);
    push_req(REQ_FREE, CELL_W'(1), 1'b0);
    push_req(REQ_NEXT, '0, 1'b0);
    push_req(REQ_NEXT, CELL_W'((MAX_SEGMENTS - 1) * CELLS_PER_SEGMENT), 1'b0);
    push_req(REQ_FREE, CELL_W'((MAX_SEGMENTS - 1) * CELLS_PER_SEGMENT), 1'b0);
    push_req(REQ_ALLOC, '0, 1'b0);
    push_req(REQ_CLEAR, '0, 1'b0);
    drain();

    run_phase(1'b1, CPS_W'(4), CPS_W'(1), 7, 55);
    run_phase(1'b1, CPS_W'(127), CPS_W'(1), 7, 55);
    run_phase(1'b1, CPS_W'(1), CPS_W'(7'h7E), 55, 7);
    run_phase(1'b1, CPS_W'(16), CPS_W'(1), 55, 7);
    run_phase(1'b1, CPS_W'(64), CPS_W'(0), 0, 0);
    write_reg(CFG_UNUSED, CPS_W'($urandom));
    run_phase(1'b0, '0, CPS_W'(1), 0, 0);

    $display("summary: %0d requests, %0d results checked, %0d register writes",
             n_accepted, n_checked, n_writes);
    $display("summary: ok %0d, no free %0d, no next %0d, bad index %0d, already free %0d",
             status_hits[int'(ST_OK)], status_hits[int'(ST_NO_FREE)],
             status_hits[int'(ST_NO_NEXT)], status_hits[int'(ST_BAD_INDEX)],
             status_hits[int'(ST_ALREADY_FREE)]);
    if (n_errors == 0) begin
      $display("tb_segmented_bitmap_cell_allocator_core: done, clean");
    end else begin
      $display("tb_segmented_bitmap_cell_allocator_core: done, errors");
    end
    $finish;
  end

endmodule
